### rtl/core/hrl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hrl_pkg
// shared types, codes and helpers for the hex record loader
// ----------------------------------------------------------------------------
package hrl_pkg;

    localparam int unsigned CharW  = 8;
    localparam int unsigned PhaseW = 3;
    localparam int unsigned KindW  = 2;
    localparam int unsigned AddrW  = 16;
    localparam int unsigned ByteW  = 8;

    // parser phases
    localparam logic [PhaseW-1:0] PH_IDLE  = 3'd0;
    localparam logic [PhaseW-1:0] PH_COUNT = 3'd1;
    localparam logic [PhaseW-1:0] PH_ADRH  = 3'd2;
    localparam logic [PhaseW-1:0] PH_ADRL  = 3'd3;
    localparam logic [PhaseW-1:0] PH_TYPE  = 3'd4;
    localparam logic [PhaseW-1:0] PH_DATA  = 3'd5;
    localparam logic [PhaseW-1:0] PH_CHECK = 3'd6;

    // result kinds
    localparam logic [KindW-1:0] KIND_WRITE = 2'd0;
    localparam logic [KindW-1:0] KIND_GOOD  = 2'd1;
    localparam logic [KindW-1:0] KIND_BAD   = 2'd2;

    // record type handled
    localparam logic [ByteW-1:0] REC_DATA = 8'h00;

    // characters
    localparam logic [CharW-1:0] CH_COLON = 8'h3A;
    localparam logic [CharW-1:0] CH_CR    = 8'h0D;
    localparam logic [CharW-1:0] CH_LF    = 8'h0A;
    localparam logic [CharW-1:0] CH_0     = 8'h30;
    localparam logic [CharW-1:0] CH_9     = 8'h39;
    localparam logic [CharW-1:0] CH_UA    = 8'h41;
    localparam logic [CharW-1:0] CH_UF    = 8'h46;
    localparam logic [CharW-1:0] CH_LA    = 8'h61;
    localparam logic [CharW-1:0] CH_LF_HEX = 8'h66;
    localparam logic [CharW-1:0] HEX_TEN  = 8'd10;

    typedef struct packed {
        logic [PhaseW-1:0] phase;
        logic              nibble_second;
        logic [3:0]        high_nibble;
        logic [ByteW-1:0]  byte_count;
        logic [AddrW-1:0]  base_address;
        logic [ByteW-1:0]  data_index;
        logic [ByteW-1:0]  record_kind;
        logic [ByteW-1:0]  running_sum;
    } t_parse_state;

    typedef struct packed {
        logic [KindW-1:0] kind;
        logic [AddrW-1:0] address;
        logic [ByteW-1:0] data;
    } t_result;

    // ascii hex digit to nibble, anything else is zero
    function automatic logic [3:0] hex_value(input logic [CharW-1:0] ch);
        logic [CharW-1:0] v;
        begin
            v = '0;
            if (ch >= CH_0 && ch <= CH_9) begin
                v = ch - CH_0;
            end else if (ch >= CH_UA && ch <= CH_UF) begin
                v = ch - CH_UA + HEX_TEN;
            end else if (ch >= CH_LA && ch <= CH_LF_HEX) begin
                v = ch - CH_LA + HEX_TEN;
            end
            return v[3:0];
        end
    endfunction

endpackage
`default_nettype wire

### rtl/core/hrl_parse.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hrl_parse
// one character step of the record parser, purely combinational
// ----------------------------------------------------------------------------
module hrl_parse
    import hrl_pkg::*;
(
    input  wire t_parse_state   i_state,
    input  wire [CharW-1:0]     i_char,
    output t_parse_state        o_state,
    output logic                o_res_valid,
    output t_result             o_res
);

    logic [3:0]       nib;
    logic [ByteW-1:0] b;
    logic [ByteW-1:0] idx_inc;
    logic             skip_char;

    always_comb begin
        nib       = hex_value(i_char);
        b         = {i_state.high_nibble, nib};
        idx_inc   = i_state.data_index + 8'd1;
        skip_char = (i_char == CH_COLON) || (i_char == CH_CR) || (i_char == CH_LF);

        o_state     = i_state;
        o_res_valid = 1'b0;
        o_res       = '0;

        if (i_state.phase == PH_IDLE || i_state.phase > PH_CHECK) begin
            if (i_char == CH_COLON) begin
                o_state.phase         = PH_COUNT;
                o_state.nibble_second = 1'b0;
                o_state.high_nibble   = '0;
                o_state.running_sum   = '0;
                o_state.data_index    = '0;
            end else begin
                o_state.phase = PH_IDLE;
            end
        end else if (!skip_char) begin
            if (!i_state.nibble_second) begin
                o_state.high_nibble   = nib;
                o_state.nibble_second = 1'b1;
            end else begin
                o_state.nibble_second = 1'b0;
                o_state.running_sum   = i_state.running_sum + b;
                case (i_state.phase)
                    PH_COUNT: begin
                        o_state.byte_count = b;
                        o_state.phase      = PH_ADRH;
                    end
                    PH_ADRH: begin
                        o_state.base_address = {b, 8'h00};
                        o_state.phase        = PH_ADRL;
                    end
                    PH_ADRL: begin
                        o_state.base_address = {i_state.base_address[AddrW-1:8], b};
                        o_state.phase        = PH_TYPE;
                    end
                    PH_TYPE: begin
                        o_state.record_kind = b;
                        o_state.data_index  = '0;
                        if (i_state.byte_count != '0 && b == REC_DATA) begin
                            o_state.phase = PH_DATA;
                        end else begin
                            o_state.phase = PH_IDLE;
                        end
                    end
                    PH_DATA: begin
                        o_res_valid        = 1'b1;
                        o_res.kind         = KIND_WRITE;
                        o_res.address      = i_state.base_address
                                           + {8'h00, i_state.data_index};
                        o_res.data         = b;
                        o_state.data_index = idx_inc;
                        if (idx_inc == i_state.byte_count) begin
                            o_state.phase = PH_CHECK;
                        end
                    end
                    default: begin
                        // checksum byte: whole record must sum to zero
                        o_res_valid   = 1'b1;
                        o_res.kind    = (o_state.running_sum == '0) ? KIND_GOOD : KIND_BAD;
                        o_state.phase = PH_IDLE;
                    end
                endcase
            end
        end
    end

endmodule
`default_nettype wire

### rtl/core/hex_record_loader.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hex_record_loader
// parses an intel hex character stream into byte writes and record status
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one ascii character per transfer in s_axis_tdata.
//   m_axis carries one result per transfer: m_axis_tuser is the kind
//   (data write, record good, checksum error), m_axis_tdata holds the
//   write address and data byte (both zero for a status result).
//   characters outside a record are dropped until ':' opens one; only
//   type 00 records with a nonzero count produce writes, then one status.
// timing:
//   one character is taken every cycle while s_axis_tready is high; a
//   character goes through an input register, the combinational parser
//   logic and the result register before its result is offered on m_axis.
// reset:
//   i_rst_n low (synchronous) empties both registers and returns the parser
//   to idle, waiting for a colon.
// stall:
//   when m_axis_tready is low with a result held, the parser stage stops;
//   the input register keeps one character, then s_axis_tready drops.
// ----------------------------------------------------------------------------
module hex_record_loader
    import hrl_pkg::*;
(
    input  wire               i_clk,
    input  wire               i_rst_n,
    // input stream
    input  wire               s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire  [7:0]        s_axis_tdata,   // [7:0] char_in
    // result stream
    output logic              m_axis_tvalid,
    input  wire               m_axis_tready,
    output logic [23:0]       m_axis_tdata,   // [15:0] write_address, [23:16] write_data
    output logic [1:0]        m_axis_tuser    // [1:0] result_kind
);

    // input register
    logic             r_in_valid;
    logic [CharW-1:0] r_in_char;

    // parser state
    t_parse_state r_state;
    t_parse_state n_state;

    // result register
    logic    r_out_valid;
    t_result r_out;

    logic    res_valid;
    t_result res;
    logic    advance;

    // parser stage may move when the result slot is free or being drained
    assign advance       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || advance;

    hrl_parse u_parse (
        .i_state     (r_state),
        .i_char      (r_in_char),
        .o_state     (n_state),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_char <= s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase         <= PH_IDLE;
            r_state.nibble_second <= 1'b0;
            r_state.high_nibble   <= '0;
            r_state.byte_count    <= '0;
            r_state.base_address  <= '0;
            r_state.data_index    <= '0;
            r_state.record_kind   <= '0;
            r_state.running_sum   <= '0;
        end else if (r_in_valid && advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid && res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid && res_valid) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out.data, r_out.address};
    assign m_axis_tuser  = r_out.kind;

endmodule
`default_nettype wire

### sim/hex_record_loader_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hex_record_loader_tb
// self-checking bench for the intel hex record loader
// ----------------------------------------------------------------------------
// a queue of ascii characters feeds a clocked stream driver; every accepted
// character runs through a local parser model that queues the writes and
// record status it should cause. a clocked monitor compares each result
// transfer against the oldest queued one. the run walks through directed
// records, then random well-formed records mixed with noise and broken
// records, under four idling profiles and one long output hold-off.
// ----------------------------------------------------------------------------
module hex_record_loader_tb;
    import hrl_pkg::*;

    localparam int unsigned HALF_PERIOD  = 1;
    localparam int unsigned RESET_CYCLES = 6;
    localparam int unsigned DRAIN_CYCLES = 20;     // wait after the last expected result of a profile
    localparam int unsigned LONG_HOLD    = 300;    // receiver hold-off that fills the pipe
    localparam int unsigned STALL_LIMIT  = 5000;   // cycles without any transfer
    localparam int unsigned PHASE_CHARS  = 425;    // random characters per idling profile
    localparam int unsigned MAX_REPORTS  = 10;

    // digit case selection for generated records
    localparam int unsigned CASE_UPPER = 0;
    localparam int unsigned CASE_LOWER = 1;
    localparam int unsigned CASE_MIXED = 2;

    // ------------------------------------------------------------------------
    // clock, reset and dut
    // ------------------------------------------------------------------------
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;    // [7:0] char_in
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;         // [15:0] write_address, [23:16] write_data
    logic [1:0]  m_axis_tuser;         // [1:0] result_kind

    always #(HALF_PERIOD) i_clk = ~i_clk;

    hex_record_loader u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // ------------------------------------------------------------------------
    // shared bench state
    // ------------------------------------------------------------------------
    logic [7:0] chars_to_send[$];          // characters waiting for the driver
    t_result    pending_load_results[$];   // writes and status still to arrive

    int unsigned send_idle_pct = 0;        // chance the sender skips a cycle
    int unsigned stall_pct     = 0;        // chance the receiver drops tready
    int unsigned hold_requests = 0;        // bumped to ask for a long hold-off
    int unsigned queued_chars  = 0;

    int unsigned chars_accepted = 0;
    int unsigned writes_seen    = 0;
    int unsigned good_seen      = 0;
    int unsigned bad_seen       = 0;
    int unsigned mismatch_count = 0;

    // parser model state
    logic [PhaseW-1:0] st_phase   = PH_IDLE;
    logic              got_high   = 1'b0;
    logic [3:0]        hi_nib     = '0;
    logic [ByteW-1:0]  rec_len    = '0;
    logic [AddrW-1:0]  rec_base   = '0;
    logic [ByteW-1:0]  rec_pos    = '0;
    logic [ByteW-1:0]  rec_type   = '0;
    logic [ByteW-1:0]  rec_sum    = '0;

    // ------------------------------------------------------------------------
    // parser model
    // ------------------------------------------------------------------------
    // digit to nibble: '0'-'9' keep their low nibble, letters are low nibble + 9
    function automatic logic [3:0] digit_value(input logic [7:0] ch);
        if (ch >= "0" && ch <= "9") begin
            return ch[3:0];
        end
        if ((ch >= "A" && ch <= "F") || (ch >= "a" && ch <= "f")) begin
            return ch[3:0] + 4'd9;
        end
        return 4'd0;
    endfunction

    task automatic parse_hex_char(input logic [7:0] ch);
        logic [3:0]       nib;
        logic [ByteW-1:0] b;
        t_result          r;
        if (st_phase == PH_IDLE || st_phase > PH_CHECK) begin
            // only a colon opens a record
            if (ch == CH_COLON) begin
                st_phase = PH_COUNT;
                got_high = 1'b0;
                hi_nib   = '0;
                rec_sum  = '0;
                rec_pos  = '0;
            end else begin
                st_phase = PH_IDLE;
            end
        end else if (ch != CH_COLON && ch != CH_CR && ch != CH_LF) begin
            nib = digit_value(ch);
            if (!got_high) begin
                hi_nib   = nib;
                got_high = 1'b1;
            end else begin
                got_high = 1'b0;
                b        = {hi_nib, nib};
                rec_sum  = rec_sum + b;
                case (st_phase)
                    PH_COUNT: begin
                        rec_len  = b;
                        st_phase = PH_ADRH;
                    end
                    PH_ADRH: begin
                        rec_base = {b, 8'h00};
                        st_phase = PH_ADRL;
                    end
                    PH_ADRL: begin
                        rec_base[7:0] = b;
                        st_phase      = PH_TYPE;
                    end
                    PH_TYPE: begin
                        rec_type = b;
                        rec_pos  = '0;
                        st_phase = (rec_len != 0 && rec_type == REC_DATA) ? PH_DATA : PH_IDLE;
                    end
                    PH_DATA: begin
                        r.kind    = KIND_WRITE;
                        r.address = rec_base + AddrW'(rec_pos);
                        r.data    = b;
                        pending_load_results.push_back(r);
                        rec_pos = rec_pos + 1'b1;
                        if (rec_pos == rec_len) begin
                            st_phase = PH_CHECK;
                        end
                    end
                    default: begin
                        // checksum byte closes the record
                        r.kind    = (rec_sum == 0) ? KIND_GOOD : KIND_BAD;
                        r.address = '0;
                        r.data    = '0;
                        pending_load_results.push_back(r);
                        st_phase = PH_IDLE;
                    end
                endcase
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // stimulus builders
    // ------------------------------------------------------------------------
    task automatic queue_char(input logic [7:0] ch);
        chars_to_send.push_back(ch);
        queued_chars++;
    endtask

    task automatic queue_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            queue_char(s[i]);
        end
    endtask

    function automatic logic [7:0] hex_digit(input logic [3:0] nib, input int unsigned dcase);
        logic lower;
        lower = (dcase == CASE_LOWER) || (dcase == CASE_MIXED && $urandom_range(0, 1) == 1);
        if (nib < 4'd10) begin
            return 8'h30 + 8'(nib);
        end
        return (lower ? 8'h61 : 8'h41) + 8'(nib) - 8'd10;
    endfunction

    // one digit, sometimes replaced by junk or followed by an ignored character
    task automatic queue_digit(input logic [3:0] nib, input int unsigned dcase,
                               input int unsigned noise_pct);
        logic [7:0] junk[3];
        junk = '{CH_COLON, CH_CR, CH_LF};
        if (noise_pct != 0 && $urandom_range(0, 99) < noise_pct / 2) begin
            queue_char(8'($urandom_range(0, 255)));
        end else begin
            queue_char(hex_digit(nib, dcase));
        end
        if (noise_pct != 0 && $urandom_range(0, 99) < noise_pct) begin
            queue_char(junk[$urandom_range(0, 2)]);
        end
    endtask

    task automatic queue_byte(input logic [7:0] b, input int unsigned dcase,
                              input int unsigned noise_pct);
        queue_digit(b[7:4], dcase, noise_pct);
        queue_digit(b[3:0], dcase, noise_pct);
    endtask

    // full record with data bytes from the list, checksum spoiled on request
    task automatic queue_record(input logic [7:0] len, input logic [15:0] addr,
                                input logic [7:0] rtype, input logic [7:0] payload[$],
                                input bit spoil, input int unsigned dcase,
                                input int unsigned noise_pct);
        logic [7:0] sum;
        sum = len + addr[15:8] + addr[7:0] + rtype;
        queue_char(CH_COLON);
        queue_byte(len, dcase, noise_pct);
        queue_byte(addr[15:8], dcase, noise_pct);
        queue_byte(addr[7:0], dcase, noise_pct);
        queue_byte(rtype, dcase, noise_pct);
        foreach (payload[i]) begin
            queue_byte(payload[i], dcase, noise_pct);
            sum = sum + payload[i];
        end
        sum = -sum;
        if (spoil) begin
            sum = sum + 8'($urandom_range(1, 255));
        end
        queue_byte(sum, dcase, noise_pct);
        queue_char(CH_CR);
        queue_char(CH_LF);
    endtask

    task automatic queue_random_item;
        logic [7:0]  payload[$];
        logic [7:0]  len;
        logic [15:0] addr;
        logic [7:0]  rtype;
        int unsigned pick;
        int unsigned n;
        pick = $urandom_range(0, 99);
        len  = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(9, 40)) : 8'($urandom_range(1, 8));
        addr = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(16'hFFF0, 16'hFFFF))
                                           : 16'($urandom_range(0, 16'hFFFF));
        if (pick < 80) begin
            // data record, mostly clean, some with a bad checksum
            for (int i = 0; i < len; i++) begin
                payload.push_back(8'($urandom_range(0, 255)));
            end
            queue_record(len, addr, REC_DATA, payload, pick >= 68,
                         $urandom_range(0, 2), ($urandom_range(0, 3) == 0) ? 4 : 0);
        end else if (pick < 88) begin
            // record the loader skips: other type or empty data record
            rtype = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(1, 255)) : REC_DATA;
            if (rtype == REC_DATA) begin
                len = '0;
            end else if ($urandom_range(0, 3) == 0) begin
                len = 8'hFF;
            end
            n = (len > 8) ? 8 : len;
            for (int i = 0; i < n; i++) begin
                payload.push_back(8'($urandom_range(0, 255)));
            end
            queue_record(len, addr, rtype, payload, 1'b0, CASE_MIXED, 0);
        end else if (pick < 95) begin
            // line noise of any byte value
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++) begin
                queue_char(8'($urandom_range(0, 255)));
            end
        end else begin
            // header cut short
            queue_char(CH_COLON);
            n = $urandom_range(0, 6);
            for (int i = 0; i < n; i++) begin
                queue_char(hex_digit(4'($urandom_range(0, 15)), CASE_MIXED));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // driver: one transfer per accepted character, model run on acceptance
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                parse_hex_char(s_axis_tdata);
                chars_accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (chars_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= chars_to_send.pop_front();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // receiver: random stalls, plus a long hold-off counted here on request
    // ------------------------------------------------------------------------
    int unsigned holds_served = 0;
    int unsigned hold_left    = 0;

    always @(posedge i_clk) begin
        if (hold_requests != holds_served) begin
            holds_served  <= hold_requests;
            hold_left     <= LONG_HOLD;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // monitor: compare each result transfer with the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_load_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS) begin
                    $display("unexpected result: kind %0d addr %h data %h",
                             m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[23:16]);
                end
            end else begin
                want = pending_load_results.pop_front();
                if (m_axis_tuser != want.kind || m_axis_tdata[15:0] != want.address ||
                    m_axis_tdata[23:16] != want.data) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("result error: kind %0d/%0d addr %h/%h data %h/%h (exp/got)",
                                 want.kind, m_axis_tuser, want.address, m_axis_tdata[15:0],
                                 want.data, m_axis_tdata[23:16]);
                    end
                end
                case (m_axis_tuser)
                    KIND_WRITE: writes_seen++;
                    KIND_GOOD:  good_seen++;
                    default:    bad_seen++;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: no transfer on either side for too long ends the run
    // ------------------------------------------------------------------------
    int unsigned quiet_cycles = 0;

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("hex_record_loader: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial begin
        int unsigned idle_profile[4];
        int unsigned stall_profile[4];
        int unsigned phase_start;
        logic [7:0]  wrap_bytes[$];
        int unsigned leftover;

        idle_profile  = '{0, 66, 0, 26};
        stall_profile = '{0, 0, 66, 26};

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: junk while idle, including cr, lf and 0xff
        queue_char(8'h00);
        queue_char(8'hFF);
        queue_char(CH_CR);
        queue_char(CH_LF);
        queue_char("7");
        // lowercase record whose second byte wraps past 0xffff
        wrap_bytes = '{8'hAB, 8'hCD};
        queue_record(8'h02, 16'hFFFF, REC_DATA, wrap_bytes, 1'b0, CASE_LOWER, 0);
        // colon and cr inside a record are ignored, checksum is wrong
        queue_text(":01:0000");
        queue_char(CH_CR);
        queue_text("00FF55");
        // non-hex digit counts as zero, checksum then still good
        queue_text(":01001000G1EE");
        // end-of-file record with zero count is skipped, trailing digits ignored
        queue_text(":00000001FF");

        for (int p = 0; p < 4; p++) begin
            send_idle_pct = idle_profile[p];
            stall_pct     = stall_profile[p];
            phase_start   = queued_chars;
            while (queued_chars - phase_start < PHASE_CHARS) begin
                queue_random_item();
            end
            // with the sender running flat out, hold the output to back up the input
            if (p == 0) begin
                hold_requests++;
            end
            while (chars_to_send.size() != 0 || s_axis_tvalid) @(posedge i_clk);
            // sender pauses until every result of this profile is in
            while (pending_load_results.size() != 0) @(posedge i_clk);
            repeat (DRAIN_CYCLES) @(posedge i_clk);
        end

        leftover = pending_load_results.size();
        $display("covered %0d characters: %0d writes, %0d good and %0d bad records",
                 chars_accepted, writes_seen, good_seen, bad_seen);
        $display("four idling profiles plus one long output hold-off, %0d errors",
                 mismatch_count + leftover);
        if (mismatch_count == 0 && leftover == 0) begin
            $display("hex_record_loader: match");
        end else begin
            $display("hex_record_loader: mismatch");
        end
        $finish;
    end

endmodule
